>>> rtl/core/point_segment_nearest_vector_core_assert.svh
// assertion macros used by the checker file
`ifndef POINT_SEGMENT_NEAREST_VECTOR_CORE_ASSERT_SVH
`define POINT_SEGMENT_NEAREST_VECTOR_CORE_ASSERT_SVH

// clocked check, quiet while reset is applied
`define PSNV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("psnv assertion failed");

// clocked check that also holds during reset
`define PSNV_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("psnv assertion failed during reset");

`endif

>>> rtl/core/psnv_pkg.sv
package psnv_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OUT_BITS       = 18;
	localparam int WIDE_BITS      = 32;

	localparam logic signed [WIDE_BITS-1:0] OUT_MAX = (1 <<< (OUT_BITS - 1)) - 1;
	localparam logic signed [WIDE_BITS-1:0] OUT_MIN = -(1 <<< (OUT_BITS - 1));

	// decisions taken once the dot products are known
	typedef struct packed {
		logic interior;
		logic near_a;
	} psnv_flags_t;

	// clamp a wide result to the output range
	function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] c;
		begin
			c = v;
			if (v > OUT_MAX) c = OUT_MAX;
			if (v < OUT_MIN) c = OUT_MIN;
			sat_out = c[OUT_BITS-1:0];
		end
	endfunction

endpackage

>>> rtl/core/psnv_if.sv
interface psnv_in_if #(parameter int COORD_BITS = psnv_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] start_z;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] end_z;

	modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
		end_x, end_y, end_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
		end_x, end_y, end_z, output ready);
endinterface

interface psnv_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [psnv_pkg::OUT_BITS-1:0]   offset_x;
	logic signed [psnv_pkg::OUT_BITS-1:0]   offset_y;
	logic signed [psnv_pkg::OUT_BITS-1:0]   offset_z;

	modport source (output valid, offset_x, offset_y, offset_z, input ready);
	modport sink (input valid, offset_x, offset_y, offset_z, output ready);
endinterface

>>> rtl/core/point_segment_nearest_vector_core.sv
// throughput: one item per cycle; the pipeline halts as a whole while the result is held
// the quotient takes one stage per multiplier bit in each of three divider lanes
// reset: valid bits and the output valid clear at once; data registers are not reset
module point_segment_nearest_vector_core #(
	parameter int COORD_BITS = psnv_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	psnv_in_if.sink      inp,
	psnv_out_if.source   res
);
	localparam int W  = COORD_BITS;
	localparam int SW = 2 * W + 3;
	localparam int N  = W + 1;
	localparam int VL = N + 3;
	localparam int WB = psnv_pkg::WIDE_BITS;

	typedef struct packed {
		logic [2:0][W:0]       pa;
		logic [2:0][W:0]       pb;
		logic [2:0]            neg;
		psnv_pkg::psnv_flags_t flags;
	} side_t;

	logic                  en;
	logic [VL-1:0]         vld_q;
	logic [2:0][W-1:0]     p, a, b;
	logic [2:0][W:0]       pa_s3, pb_s3, d_s3;
	logic [SW-1:0]         tnum_s3, dd_s3, num;
	psnv_pkg::psnv_flags_t flags_s3;
	side_t                 side_in;
	side_t                 side_q [N];
	logic [2:0][W:0]       mag;
	logic [2:0][W+1:0]     quo;
	logic [2:0][psnv_pkg::OUT_BITS-1:0] outv;

	// whole pipeline moves unless a result waits
	assign en        = !res.valid || res.ready;
	assign inp.ready = en;

	assign p = {inp.point_z, inp.point_y, inp.point_x};
	assign a = {inp.start_z, inp.start_y, inp.start_x};
	assign b = {inp.end_z, inp.end_y, inp.end_x};

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			res.valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[VL-2:0], inp.valid};
			res.valid <= vld_q[VL-1];
		end
	end

	psnv_front #(.W(W)) u_front (
		.clk      (clk),
		.en       (en),
		.p        (p),
		.a        (a),
		.b        (b),
		.pa_s3    (pa_s3),
		.pb_s3    (pb_s3),
		.d_s3     (d_s3),
		.tnum_s3  (tnum_s3),
		.dd_s3    (dd_s3),
		.flags_s3 (flags_s3)
	);

	// divider operands
	assign num = flags_s3.interior ? tnum_s3 : '0;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = d_s3[i][W] ? -d_s3[i] : d_s3[i];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		psnv_div #(.W(W)) u_div (
			.clk (clk),
			.en  (en),
			.num (num),
			.den (dd_s3),
			.mul (mag[i]),
			.q   (quo[i])
		);
	end

	// side data delay matching the divider
	assign side_in.pa    = pa_s3;
	assign side_in.pb    = pb_s3;
	assign side_in.neg   = {d_s3[2][W], d_s3[1][W], d_s3[0][W]};
	assign side_in.flags = flags_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// pick the nearest point and clamp
	always_comb begin
		logic signed [WB-1:0] qs, pav, pbv, rv;
		for (int i = 0; i < 3; i++) begin
			qs  = WB'($signed({1'b0, quo[i]}));
			if (side_q[N-1].neg[i]) qs = -qs;
			pav = WB'($signed(side_q[N-1].pa[i]));
			pbv = WB'($signed(side_q[N-1].pb[i]));
			if (side_q[N-1].flags.interior) rv = qs - pav;
			else if (side_q[N-1].flags.near_a) rv = -pav;
			else rv = -pbv;
			outv[i] = psnv_pkg::sat_out(rv);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.offset_x <= outv[0];
			res.offset_y <= outv[1];
			res.offset_z <= outv[2];
		end
	end

endmodule

>>> rtl/core/psnv_front.sv
module psnv_front #(
	parameter int W = psnv_pkg::COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2:0][W-1:0]      p,
	input  logic [2:0][W-1:0]      a,
	input  logic [2:0][W-1:0]      b,
	output logic [2:0][W:0]        pa_s3,
	output logic [2:0][W:0]        pb_s3,
	output logic [2:0][W:0]        d_s3,
	output logic [2*W+2:0]         tnum_s3,
	output logic [2*W+2:0]         dd_s3,
	output psnv_pkg::psnv_flags_t  flags_s3
);
	localparam int PW = 2 * W + 2;
	localparam int SW = 2 * W + 3;

	logic [2:0][W:0]    pa_s1, pb_s1, d_s1, pa_s2, pb_s2, d_s2;
	logic [2:0][PW-1:0] tn_s2, te_s2, dd_s2, m1_s2, m2_s2;
	logic signed [SW-1:0] tn_sum, te_sum, dd_sum, m1_sum, m2_sum;

	// stage 1: coordinate differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= {b[i][W-1], b[i]} - {a[i][W-1], a[i]};
				pa_s1[i] <= {p[i][W-1], p[i]} - {a[i][W-1], a[i]};
				pb_s1[i] <= {p[i][W-1], p[i]} - {b[i][W-1], b[i]};
			end
		end
	end

	// stage 2: products for the dot terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tn_s2[i] <= PW'($signed(pa_s1[i]) * $signed(d_s1[i]));
				te_s2[i] <= PW'($signed(pb_s1[i]) * $signed(d_s1[i]));
				dd_s2[i] <= PW'($signed(d_s1[i]) * $signed(d_s1[i]));
				m1_s2[i] <= PW'($signed(pa_s1[i]) * $signed(pa_s1[i]));
				m2_s2[i] <= PW'($signed(pb_s1[i]) * $signed(pb_s1[i]));
			end
			pa_s2 <= pa_s1;
			pb_s2 <= pb_s1;
			d_s2  <= d_s1;
		end
	end

	// stage 3: dot sums and the end tests
	always_comb begin
		tn_sum = SW'($signed(tn_s2[0])) + SW'($signed(tn_s2[1])) + SW'($signed(tn_s2[2]));
		te_sum = SW'($signed(te_s2[0])) + SW'($signed(te_s2[1])) + SW'($signed(te_s2[2]));
		dd_sum = SW'($signed(dd_s2[0])) + SW'($signed(dd_s2[1])) + SW'($signed(dd_s2[2]));
		m1_sum = SW'($signed(m1_s2[0])) + SW'($signed(m1_s2[1])) + SW'($signed(m1_s2[2]));
		m2_sum = SW'($signed(m2_s2[0])) + SW'($signed(m2_s2[1])) + SW'($signed(m2_s2[2]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tnum_s3           <= tn_sum;
			dd_s3             <= dd_sum;
			flags_s3.interior <= (tn_sum > 0) && (te_sum < 0);
			flags_s3.near_a   <= m1_sum < m2_sum;
			pa_s3             <= pa_s2;
			pb_s3             <= pb_s2;
			d_s3              <= d_s2;
		end
	end

endmodule

>>> rtl/core/psnv_div.sv
module psnv_div #(
	parameter int W = psnv_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [2*W+2:0]     num,
	input  logic [2*W+2:0]     den,
	input  logic [W:0]         mul,
	output logic [W+1:0]       q
);
	localparam int DW = 2 * W + 3;
	localparam int N  = W + 1;
	localparam int QW = W + 2;

	logic [DW-1:0] r_s   [N-1];
	logic [QW-1:0] q_s   [N];
	logic [DW-1:0] num_s [N-1];
	logic [DW-1:0] den_s [N-1];
	logic [W:0]    mul_s [N-1];

	// one multiplier bit per stage, most significant first
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [DW-1:0] r_in, n_in, dn_in, r2, ra;
		logic [QW-1:0] q_in, q2, qa;
		logic [W:0]    m_in;

		// operands from the stage before
		if (k == 0) begin : g_first
			assign r_in  = '0;
			assign q_in  = '0;
			assign n_in  = num;
			assign dn_in = den;
			assign m_in  = mul;
		end else begin : g_next
			assign r_in  = r_s[k-1];
			assign q_in  = q_s[k-1];
			assign n_in  = num_s[k-1];
			assign dn_in = den_s[k-1];
			assign m_in  = mul_s[k-1];
		end

		always_comb begin
			r2 = {r_in[DW-2:0], 1'b0};
			q2 = {q_in[QW-2:0], 1'b0};
			if (r2 >= dn_in) begin
				r2 = r2 - dn_in;
				q2 = q2 + 1'b1;
			end
			ra = m_in[W-k] ? r2 + n_in : r2;
			qa = q2;
			if (ra >= dn_in) begin
				ra = ra - dn_in;
				qa = qa + 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= qa;
			end
		end

		// remainder and operands travel on to the next stage
		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k]   <= ra;
					num_s[k] <= n_in;
					den_s[k] <= dn_in;
					mul_s[k] <= m_in;
				end
			end
		end
	end

	assign q = q_s[N-1];

endmodule

>>> rtl/core/psnv_check.sv
`include "point_segment_nearest_vector_core_assert.svh"

module psnv_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          inp_valid,
	input logic                          inp_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [psnv_pkg::OUT_BITS-1:0] res_x,
	input logic [psnv_pkg::OUT_BITS-1:0] res_y,
	input logic [psnv_pkg::OUT_BITS-1:0] res_z
);
	logic [3*psnv_pkg::OUT_BITS-1:0] res_all;
	assign res_all = {res_x, res_y, res_z};

	// input stalls only behind a blocked result
	`PSNV_ASSERT(a_ready_rule, inp_ready == (!res_valid || res_ready))
	// a blocked result stays offered
	`PSNV_ASSERT(a_hold_valid, res_valid && !res_ready |=> res_valid)
	// and keeps its value
	`PSNV_ASSERT(a_hold_data, res_valid && !res_ready |=> $stable(res_all))
	// input handshake lines are known outside reset
	`PSNV_ASSERT(a_hs_known, !$isunknown({inp_valid, inp_ready}))
	// nothing is offered under reset
	`PSNV_ASSERT_RST(a_reset_quiet, !arst_n |-> !res_valid)

endmodule

bind point_segment_nearest_vector_core psnv_check u_psnv_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.inp_valid (inp.valid),
	.inp_ready (inp.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_x     (res.offset_x),
	.res_y     (res.offset_y),
	.res_z     (res.offset_z)
);

>>> verif/tb_point_segment_nearest_vector_core.sv
`timescale 1ns / 100ps

module tb_point_segment_nearest_vector_core;

	localparam int CB = psnv_pkg::COORD_BITS_DEF;
	localparam int OB = psnv_pkg::OUT_BITS;
	localparam int LATENCY = CB + 5;
	localparam int HOLD_LEN = 200;

	typedef struct {
		logic signed [CB-1:0] px, py, pz, ax, ay, az, bx, by, bz;
	} query_t;

	typedef struct {
		logic signed [OB-1:0] ox, oy, oz;
	} offset_t;

	logic clk;
	logic arst_n;

	psnv_in_if #(.COORD_BITS(CB)) inp ();
	psnv_out_if res ();

	point_segment_nearest_vector_core #(.COORD_BITS(CB)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (inp.sink),
		.res    (res.source)
	);

	query_t  pending_queries[$];
	offset_t expected_offsets[$];
	int      n_errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      send_idle_pct = 11;
	int      recv_idle_pct = 73;
	int      hold_cycles = 0;
	int      hold_reqs = 0;
	int      hold_taken = 0;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// clamp to the output range
	function automatic logic signed [OB-1:0] clamp18(input longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (OB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[OB-1:0];
	endfunction

	// nearest-point offset from the query point to the segment
	function automatic offset_t nearest_offset(input query_t q);
		longint p[3], a[3], b[3], d[3], pa[3], pb[3], ap[3], bp[3], r[3];
		longint t_num, t_end, dd, m1, m2, mag, quo;
		offset_t o;
		p = '{q.px, q.py, q.pz};
		a = '{q.ax, q.ay, q.az};
		b = '{q.bx, q.by, q.bz};
		for (int i = 0; i < 3; i++) begin
			d[i] = b[i] - a[i];
			pa[i] = p[i] - a[i];
			pb[i] = p[i] - b[i];
			ap[i] = a[i] - p[i];
			bp[i] = b[i] - p[i];
		end
		t_num = pa[0]*d[0] + pa[1]*d[1] + pa[2]*d[2];
		t_end = pb[0]*d[0] + pb[1]*d[1] + pb[2]*d[2];
		dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		m1 = ap[0]*ap[0] + ap[1]*ap[1] + ap[2]*ap[2];
		m2 = bp[0]*bp[0] + bp[1]*bp[1] + bp[2]*bp[2];
		if (t_num > 0 && t_end < 0) begin
			// exact product fits: t_num < 2^35, mag < 2^17
			for (int i = 0; i < 3; i++) begin
				mag = d[i] < 0 ? -d[i] : d[i];
				quo = (t_num * mag) / dd;
				if (d[i] < 0) quo = -quo;
				r[i] = quo - pa[i];
			end
		end else if (m1 < m2) begin
			r = ap;
		end else begin
			r = bp;
		end
		o.ox = clamp18(r[0]);
		o.oy = clamp18(r[1]);
		o.oz = clamp18(r[2]);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, n_checked);
		n_errors++;
	endtask

	function automatic logic signed [CB-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(CB-1){1'b1}}};
			1: return {1'b1, {(CB-1){1'b0}}};
			2: return CB'(int'($urandom_range(0, 15)) - 8);
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic query_t mk(input int px, py, pz, ax, ay, az, bx, by, bz);
		query_t q;
		q.px = CB'(px); q.py = CB'(py); q.pz = CB'(pz);
		q.ax = CB'(ax); q.ay = CB'(ay); q.az = CB'(az);
		q.bx = CB'(bx); q.by = CB'(by); q.bz = CB'(bz);
		return q;
	endfunction

	// random query, often built to land inside the segment
	function automatic query_t rand_query();
		query_t q;
		int sel;
		q = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord());
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			// point near the middle of a modest segment
			q.ax = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.ay = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.az = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.bx = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.by = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.bz = CB'(int'($urandom_range(0, 8000)) - 4000);
			q.px = CB'((int'(q.ax) + int'(q.bx)) / 2 + int'($urandom_range(0, 4000)) - 2000);
			q.py = CB'((int'(q.ay) + int'(q.by)) / 2 + int'($urandom_range(0, 4000)) - 2000);
			q.pz = CB'((int'(q.az) + int'(q.bz)) / 2 + int'($urandom_range(0, 4000)) - 2000);
		end else if (sel == 4) begin
			q.bx = q.ax; q.by = q.ay; q.bz = q.az;
		end
		return q;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inp.valid <= 1'b0;
			inp.point_x <= '0; inp.point_y <= '0; inp.point_z <= '0;
			inp.start_x <= '0; inp.start_y <= '0; inp.start_z <= '0;
			inp.end_x <= '0; inp.end_y <= '0; inp.end_z <= '0;
		end else begin
			if (inp.valid && inp.ready) begin
				expected_offsets.push_back(nearest_offset(pending_queries.pop_front()));
				n_sent++;
			end
			if (!(inp.valid && !inp.ready)) begin
				if (pending_queries.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
					inp.valid <= 1'b1;
					inp.point_x <= pending_queries[0].px;
					inp.point_y <= pending_queries[0].py;
					inp.point_z <= pending_queries[0].pz;
					inp.start_x <= pending_queries[0].ax;
					inp.start_y <= pending_queries[0].ay;
					inp.start_z <= pending_queries[0].az;
					inp.end_x <= pending_queries[0].bx;
					inp.end_y <= pending_queries[0].by;
					inp.end_z <= pending_queries[0].bz;
				end else begin
					inp.valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off counter for the receiver
	always @(posedge clk) begin
		if (hold_taken != hold_reqs) begin
			hold_cycles <= HOLD_LEN;
			hold_taken <= hold_reqs;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		offset_t e;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_offsets.size() == 0) begin
					report_mismatch("unexpected result item", res.offset_x, 0);
				end else begin
					e = expected_offsets.pop_front();
					if (res.offset_x !== e.ox) report_mismatch("offset_x", res.offset_x, e.ox);
					if (res.offset_y !== e.oy) report_mismatch("offset_y", res.offset_y, e.oy);
					if (res.offset_z !== e.oz) report_mismatch("offset_z", res.offset_z, e.oz);
				end
				n_checked++;
			end
			res.ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_queries.size() > 0 || inp.valid || expected_offsets.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int mx, mn;
		mx = (1 << (CB - 1)) - 1;
		mn = -(1 << (CB - 1));
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, degenerate segment, ties, projection on an end, interior
		pending_queries.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_queries.push_back(mk(mx, mx, mx, mn, mn, mn, mn, mn, mn));
		pending_queries.push_back(mk(mn, mn, mn, mx, mx, mx, mx, mx, mx));
		pending_queries.push_back(mk(mx, mn, mx, mn, mx, mn, mx, mn, mx));
		pending_queries.push_back(mk(0, 0, 0, mn, mn, mn, mx, mx, mx));
		pending_queries.push_back(mk(mx, mx, mx, mn, mn, mn, mx, mx, mn));
		pending_queries.push_back(mk(5, 7, 9, 5, 7, 9, 5, 7, 9));
		pending_queries.push_back(mk(0, 5, 0, -10, 0, 0, 10, 0, 0));
		pending_queries.push_back(mk(0, 0, 0, -3, 4, 0, 3, 4, 0));
		pending_queries.push_back(mk(-10, 3, 0, -10, 0, 0, 10, 0, 0));
		pending_queries.push_back(mk(10, 3, 0, -10, 0, 0, 10, 0, 0));
		pending_queries.push_back(mk(1, 1, 1, 0, 0, 0, 3, 7, 2));
		pending_queries.push_back(mk(1, 2, 3, 7, 7, 7, -5, -1, 4));
		pending_queries.push_back(mk(-20, 9, 1, -10, 0, 0, 10, 0, 0));
		pending_queries.push_back(mk(20, -9, 1, -10, 0, 0, 10, 0, 0));
		pending_queries.push_back(mk(mn, mx, 0, mx, mn, 0, mn, mn, 0));
		pending_queries.push_back(mk(100, -100, 50, mn, 0, mx, mx, 0, mn));
		pending_queries.push_back(mk(-1, -1, -1, 0, 0, 0, 0, 0, 0));
		pending_queries.push_back(mk(3, 0, 0, 0, 0, 0, 7, 1, -1));
		wait_drained();

		// random, sender mostly offering and receiver mostly not ready
		for (int i = 0; i < 350; i++) pending_queries.push_back(rand_query());
		wait_drained();

		// receiver stalls for a long stretch while the sender keeps offering
		hold_reqs++;
		for (int i = 0; i < 100; i++) pending_queries.push_back(rand_query());
		wait_drained();

		// roles swapped
		send_idle_pct = 73;
		recv_idle_pct = 11;
		for (int i = 0; i < 350; i++) pending_queries.push_back(rand_query());
		wait_drained();

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 300; i++) pending_queries.push_back(rand_query());
		wait_drained();

		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d items through a %0d-stage pipeline under stall and backpressure",
			n_sent, LATENCY);
		$display("extreme, degenerate, tie, endpoint and interior projections exercised");
		if (n_errors == 0 && expected_offsets.size() == 0) begin
			$display("tb_point_segment_nearest_vector_core: PASS");
		end else begin
			$display("tb_point_segment_nearest_vector_core: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("tb_point_segment_nearest_vector_core: FAIL");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/psnv_pkg.sv
rtl/core/psnv_if.sv
rtl/core/psnv_front.sv
rtl/core/psnv_div.sv
rtl/core/point_segment_nearest_vector_core.sv
rtl/core/psnv_check.sv
verif/tb_point_segment_nearest_vector_core.sv
